### design/jpeg_pixel_color_transfer_top_macros.svh
// Assertion macros used by the checker file of the pixel color block.
`ifndef JPEG_PIXEL_COLOR_TRANSFER_TOP_MACROS_SVH
`define JPEG_PIXEL_COLOR_TRANSFER_TOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define JPCT_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold at the same edge.
`define JPCT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### design/jpct_pkg.sv
package jpct_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LANES    = 4;
	// Numerator of the final scaling, m * 65535 with m up to 50 bits.
	localparam int NUM_W    = 66;
	// Divisor is either the sample maximum or its square.
	localparam int DEN_W    = 32;
	// Quotient bits kept by the divider (result bits 31 down to 15).
	localparam int QUO_W    = SAMPLE_W + 1;

	// JFIF matrix coefficients in Q0.24.
	localparam logic [23:0] COEF_R   = 24'hB374BC;
	localparam logic [23:0] COEF_B   = 24'hE2D0E5;
	localparam logic [23:0] COEF_GCR = 24'h5B68D1;
	localparam logic [23:0] COEF_GCB = 24'h2C0CA8;

	typedef enum logic [3:0] {
		MODE_GRAY       = 4'd0,
		MODE_GRAY_ALPHA = 4'd1,
		MODE_RGB        = 4'd2,
		MODE_BGR        = 4'd3,
		MODE_ABGR       = 4'd4,
		MODE_YCBCR      = 4'd5,
		MODE_CBYCR      = 4'd6,
		MODE_YCBCRK     = 4'd7,
		MODE_CBKYCR     = 4'd8,
		MODE_ACBYCR     = 4'd9,
		MODE_CMYK       = 4'd10,
		MODE_CKMY       = 4'd11
	} mode_t;

	typedef enum logic [1:0] {
		REG_LAYOUT_MODE = 2'd0,
		REG_SAMPLE_MAX  = 2'd1
	} reg_idx_t;

	localparam logic [3:0]          LAYOUT_MODE_RESET = MODE_YCBCR;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX_RESET  = 16'd255;

	// Request into the scaling divider: four numerators sharing one divisor.
	typedef struct packed {
		logic                            valid;
		logic                            run_end;
		logic [LANES-1:0][NUM_W-1:0]     num;
		logic [DEN_W-1:0]                den;
	} div_req_t;

	// Rounded and saturated channels leaving the divider.
	typedef struct packed {
		logic                            valid;
		logic                            run_end;
		logic [LANES-1:0][SAMPLE_W-1:0]  chan;
	} div_rsp_t;

endpackage

### design/jpct_div.sv
// Pipelined restoring divider, one quotient bit per stage, four lanes.
// Gives min(65535, round(num / (den * 65536))) for each lane.
module jpct_div (
	input  logic                clk,
	input  logic                arst_n,
	input  jpct_pkg::div_req_t  req,
	output jpct_pkg::div_rsp_t  rsp
);

	localparam int STEPS  = jpct_pkg::QUO_W;
	localparam int LANES  = jpct_pkg::LANES;
	localparam int DEN_W  = jpct_pkg::DEN_W;
	localparam int NUM_W  = jpct_pkg::NUM_W;
	localparam int SW     = jpct_pkg::SAMPLE_W;
	// Bit of the numerator at which the output scale of 65536 * 65536 sits.
	localparam int SPLIT  = 2 * SW;
	localparam int LO_LSB = SPLIT - STEPS;

	// Index 0 is the entry stage, index STEPS holds the finished quotient.
	logic                 valid_sn   [0:STEPS];
	logic                 run_end_sn [0:STEPS];
	logic [DEN_W-1:0]     den_sn     [0:STEPS];
	logic [LANES-1:0]     sat_sn     [0:STEPS];
	logic [DEN_W-1:0]     rem_sn     [0:STEPS][0:LANES-1];
	logic [STEPS-1:0]     quo_sn     [0:STEPS][0:LANES-1];
	logic [STEPS-1:0]     low_sn     [0:STEPS][0:LANES-1];

	logic                 done_q;
	logic                 run_end_q;
	logic [LANES-1:0][SW-1:0] chan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= STEPS; i++) begin
				valid_sn[i] <= 1'b0;
			end
			done_q <= 1'b0;
		end else begin
			valid_sn[0] <= req.valid;
			for (int i = 1; i <= STEPS; i++) begin
				valid_sn[i] <= valid_sn[i-1];
			end
			done_q <= valid_sn[STEPS];
		end
	end

	// Entry: a quotient of 2**STEPS or more saturates at once.
	always_ff @(posedge clk) begin
		run_end_sn[0] <= req.run_end;
		den_sn[0]     <= req.den;
		for (int l = 0; l < LANES; l++) begin
			sat_sn[0][l] <= req.num[l][NUM_W-1:SPLIT] >= (NUM_W - SPLIT)'(req.den);
			rem_sn[0][l] <= req.num[l][SPLIT+DEN_W-1:SPLIT];
			low_sn[0][l] <= req.num[l][SPLIT-1:LO_LSB];
			quo_sn[0][l] <= '0;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		always_ff @(posedge clk) begin
			run_end_sn[k+1] <= run_end_sn[k];
			den_sn[k+1]     <= den_sn[k];
			sat_sn[k+1]     <= sat_sn[k];
		end
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DEN_W:0] trial;
			logic           fits;
			assign trial = {rem_sn[k][l], low_sn[k][l][STEPS-1]};
			assign fits  = trial >= {1'b0, den_sn[k]};
			always_ff @(posedge clk) begin
				rem_sn[k+1][l] <= fits ? DEN_W'(trial - {1'b0, den_sn[k]}) : trial[DEN_W-1:0];
				quo_sn[k+1][l] <= {quo_sn[k][l][STEPS-2:0], fits};
				low_sn[k+1][l] <= {low_sn[k][l][STEPS-2:0], 1'b0};
			end
		end
	end

	// Round half up by dropping the last quotient bit, then clamp.
	for (genvar l = 0; l < LANES; l++) begin : g_round
		logic [STEPS:0]   sum;
		logic [STEPS-1:0] rnd;
		assign sum = {1'b0, quo_sn[STEPS][l]} + (STEPS + 1)'(1);
		assign rnd = sum[STEPS:1];
		always_ff @(posedge clk) begin
			chan_q[l] <= (sat_sn[STEPS][l] || rnd[STEPS-1]) ? '1 : rnd[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		run_end_q <= run_end_sn[STEPS];
	end

	assign rsp.valid   = done_q;
	assign rsp.run_end = run_end_q;
	assign rsp.chan    = chan_q;

endmodule

### design/jpeg_pixel_color_transfer_top.sv
// Pixel color transfer for a JPEG decoder: one pixel of up to four component
// samples in, one 16-bit RGBA pixel out.
// A transaction enters when start is high at a rising clock edge while busy
// is low. The block is a fixed pipeline that never holds off its source, so
// busy stays low and a new pixel may be presented in every cycle.
// The result of each transaction shows on red_out, green_out, blue_out,
// alpha_out and run_end_out for exactly one cycle while done is high.
// Results leave in the order the pixels came in, one per cycle at most.
// Its stages are the 17 quotient bits of the output scaling divider, one
// bit per stage, plus six stages of unpacking, matrix, K multiply and
// numerator build and two stages of divider setup and rounding.
// The receiver cannot stall the block; it must take each result as shown.
// The user writes layout_mode and sample_max registers via cfg_we, cfg_addr
// and cfg_wdata only while no pixel is in flight; the block does not check.
// Reset clears the pipeline valid bits, drops any pixel in flight, and loads
// layout_mode with YCbCr and sample_max with 255.
module jpeg_pixel_color_transfer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] sample_a,
	input  logic [15:0] sample_b,
	input  logic [15:0] sample_c,
	input  logic [15:0] sample_d,
	input  logic        end_of_run,
	output logic        done,
	output logic [15:0] red_out,
	output logic [15:0] green_out,
	output logic [15:0] blue_out,
	output logic [15:0] alpha_out,
	output logic        run_end_out,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	// Configuration registers.
	logic [3:0]  mode_q;
	logic [15:0] smax_q;
	logic [15:0] lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jpct_pkg::LAYOUT_MODE_RESET;
			smax_q <= jpct_pkg::SAMPLE_MAX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				jpct_pkg::REG_LAYOUT_MODE: mode_q <= cfg_wdata[3:0];
				jpct_pkg::REG_SAMPLE_MAX:  smax_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// A sample maximum of zero behaves as one.
	assign lim  = (smax_q == '0) ? 16'd1 : smax_q;
	assign busy = 1'b0;

	// Valid bits of stages 1 to 6.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: capture the pixel together with the configuration it uses.
	logic [15:0] a_s1, b_s1, c_s1, d_s1, lim_s1;
	logic [3:0]  mode_s1;
	logic        eor_s1;

	always_ff @(posedge clk) begin
		a_s1    <= sample_a;
		b_s1    <= sample_b;
		c_s1    <= sample_c;
		d_s1    <= sample_d;
		eor_s1  <= end_of_run;
		mode_s1 <= mode_q;
		lim_s1  <= lim;
	end

	// Stage 2: pick components by layout and form the chroma offsets L - 2C.
	logic [15:0]        mux_y, mux_cb, mux_cr, mux_k, mux_am;
	logic [2:0][15:0]   mux_p;
	logic               mux_ycc, mux_kmode, mux_alpha;
	logic signed [17:0] mux_ob, mux_or;

	always_comb begin
		mux_y     = '0;
		mux_cb    = '0;
		mux_cr    = '0;
		mux_k     = '0;
		mux_p     = '0;
		mux_ycc   = 1'b0;
		mux_kmode = 1'b0;
		mux_alpha = 1'b0;
		unique case (mode_s1)
			jpct_pkg::MODE_GRAY: begin
				mux_p = {a_s1, a_s1, a_s1};
			end
			jpct_pkg::MODE_GRAY_ALPHA: begin
				mux_p     = {b_s1, b_s1, b_s1};
				mux_alpha = 1'b1;
			end
			jpct_pkg::MODE_RGB: begin
				mux_p = {c_s1, b_s1, a_s1};
			end
			jpct_pkg::MODE_BGR: begin
				mux_p = {a_s1, b_s1, c_s1};
			end
			jpct_pkg::MODE_ABGR: begin
				mux_p     = {b_s1, c_s1, d_s1};
				mux_alpha = 1'b1;
			end
			jpct_pkg::MODE_YCBCR: begin
				mux_ycc = 1'b1;
				mux_y   = a_s1;
				mux_cb  = b_s1;
				mux_cr  = c_s1;
			end
			jpct_pkg::MODE_CBYCR: begin
				mux_ycc = 1'b1;
				mux_y   = b_s1;
				mux_cb  = a_s1;
				mux_cr  = c_s1;
			end
			jpct_pkg::MODE_YCBCRK: begin
				mux_ycc   = 1'b1;
				mux_y     = a_s1;
				mux_cb    = b_s1;
				mux_cr    = c_s1;
				mux_kmode = 1'b1;
				mux_k     = d_s1;
			end
			jpct_pkg::MODE_CBKYCR: begin
				mux_ycc   = 1'b1;
				mux_y     = c_s1;
				mux_cb    = a_s1;
				mux_cr    = d_s1;
				mux_kmode = 1'b1;
				mux_k     = b_s1;
			end
			jpct_pkg::MODE_ACBYCR: begin
				mux_ycc   = 1'b1;
				mux_y     = c_s1;
				mux_cb    = b_s1;
				mux_cr    = d_s1;
				mux_alpha = 1'b1;
			end
			jpct_pkg::MODE_CMYK: begin
				mux_p     = {c_s1, b_s1, a_s1};
				mux_kmode = 1'b1;
				mux_k     = d_s1;
			end
			jpct_pkg::MODE_CKMY: begin
				mux_p     = {d_s1, c_s1, a_s1};
				mux_kmode = 1'b1;
				mux_k     = b_s1;
			end
			default: ;
		endcase
		mux_ob = $signed({2'b00, lim_s1}) - $signed({1'b0, mux_cb, 1'b0});
		mux_or = $signed({2'b00, lim_s1}) - $signed({1'b0, mux_cr, 1'b0});
		// Inverted alpha; a sample at or above the maximum is fully opaque.
		mux_am = (mux_alpha && (a_s1 < lim_s1)) ? lim_s1 - a_s1 : '0;
	end

	logic [15:0]        y_s2, k_s2, am_s2, lim_s2;
	logic [2:0][15:0]   p_s2;
	logic               ycc_s2, kmode_s2, eor_s2;
	logic signed [17:0] ob_s2, or_s2;

	always_ff @(posedge clk) begin
		y_s2     <= mux_y;
		k_s2     <= mux_k;
		am_s2    <= mux_am;
		lim_s2   <= lim_s1;
		p_s2     <= mux_p;
		ycc_s2   <= mux_ycc;
		kmode_s2 <= mux_kmode;
		eor_s2   <= eor_s1;
		ob_s2    <= mux_ob;
		or_s2    <= mux_or;
	end

	// Stage 3: the four matrix products in Q.24.
	logic signed [42:0] pr_s3, pgb_s3, pgr_s3, pb_s3;
	logic [15:0]        y_s3, k_s3, am_s3, lim_s3;
	logic [2:0][15:0]   p_s3;
	logic               ycc_s3, kmode_s3, eor_s3;

	always_ff @(posedge clk) begin
		pr_s3    <= $signed({1'b0, jpct_pkg::COEF_R}) * or_s2;
		pgb_s3   <= $signed({1'b0, jpct_pkg::COEF_GCB}) * ob_s2;
		pgr_s3   <= $signed({1'b0, jpct_pkg::COEF_GCR}) * or_s2;
		pb_s3    <= $signed({1'b0, jpct_pkg::COEF_B}) * ob_s2;
		y_s3     <= y_s2;
		k_s3     <= k_s2;
		am_s3    <= am_s2;
		lim_s3   <= lim_s2;
		p_s3     <= p_s2;
		ycc_s3   <= ycc_s2;
		kmode_s3 <= kmode_s2;
		eor_s3   <= eor_s2;
	end

	// Stage 4: sum in Q.24 with the rounding half added, drop to Q.16 and
	// clamp negative values to zero; non-YCbCr modes pass samples as Q.16.
	logic signed [44:0] yq, t_r, t_g, t_b;
	logic [2:0][33:0]   mval;

	assign yq  = $signed({5'b0, y_s3, 24'b0});
	assign t_r = yq - pr_s3 + 45'sd128;
	assign t_g = yq + pgb_s3 + pgr_s3 + 45'sd128;
	assign t_b = yq - pb_s3 + 45'sd128;

	always_comb begin
		if (ycc_s3) begin
			mval[0] = t_r[44] ? '0 : t_r[41:8];
			mval[1] = t_g[44] ? '0 : t_g[41:8];
			mval[2] = t_b[44] ? '0 : t_b[41:8];
		end else begin
			for (int l = 0; l < 3; l++) begin
				mval[l] = {2'b00, p_s3[l], 16'b0};
			end
		end
	end

	logic [2:0][33:0] m_s4;
	logic [15:0]      k_s4, am_s4, lim_s4;
	logic             kmode_s4, eor_s4;

	always_ff @(posedge clk) begin
		m_s4     <= mval;
		k_s4     <= k_s3;
		am_s4    <= am_s3;
		lim_s4   <= lim_s3;
		kmode_s4 <= kmode_s3;
		eor_s4   <= eor_s3;
	end

	// Stage 5: K modes multiply the color by K and divide by L^2, others by L.
	logic [3:0][49:0] mk_s5;
	logic [31:0]      den_s5;
	logic             eor_s5;

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			mk_s5[l] <= kmode_s4 ? m_s4[l] * k_s4 : {16'b0, m_s4[l]};
		end
		mk_s5[3] <= {18'b0, am_s4, 16'b0};
		den_s5   <= kmode_s4 ? lim_s4 * lim_s4 : {16'b0, lim_s4};
		eor_s5   <= eor_s4;
	end

	// Stage 6: numerator m * 65535 for the output scaling.
	logic [3:0][65:0] num_s6;
	logic [31:0]      den_s6;
	logic             eor_s6;

	always_ff @(posedge clk) begin
		for (int l = 0; l < 4; l++) begin
			num_s6[l] <= {mk_s5[l], 16'b0} - {16'b0, mk_s5[l]};
		end
		den_s6 <= den_s5;
		eor_s6 <= eor_s5;
	end

	jpct_pkg::div_req_t div_req;
	jpct_pkg::div_rsp_t div_rsp;

	assign div_req.valid   = v_s6;
	assign div_req.run_end = eor_s6;
	assign div_req.num     = num_s6;
	assign div_req.den     = den_s6;

	jpct_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign done        = div_rsp.valid;
	assign run_end_out = div_rsp.run_end;
	assign red_out     = div_rsp.chan[0];
	assign green_out   = div_rsp.chan[1];
	assign blue_out    = div_rsp.chan[2];
	assign alpha_out   = div_rsp.chan[3];

endmodule

### design/jpct_checker.sv
`include "jpeg_pixel_color_transfer_top_macros.svh"

// Port level checks of the pixel color block.
module jpct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [15:0] sample_a,
	input logic [15:0] sample_b,
	input logic [15:0] sample_c,
	input logic [15:0] sample_d,
	input logic        end_of_run,
	input logic        done,
	input logic [15:0] red_out,
	input logic [15:0] green_out,
	input logic [15:0] blue_out,
	input logic [15:0] alpha_out,
	input logic        run_end_out,
	input logic        cfg_we,
	input logic [1:0]  cfg_addr,
	input logic [15:0] cfg_wdata
);

	localparam int LAT = 25;

	logic        acc;
	logic        prev_acc_q;
	logic        prev_we_q;
	logic [15:0] prev_a_q, prev_b_q, prev_c_q, prev_d_q;
	logic        repeat_pix;

	assign acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_acc_q <= 1'b0;
			prev_we_q  <= 1'b0;
		end else begin
			prev_acc_q <= acc;
			prev_we_q  <= cfg_we;
		end
	end

	always_ff @(posedge clk) begin
		prev_a_q <= sample_a;
		prev_b_q <= sample_b;
		prev_c_q <= sample_c;
		prev_d_q <= sample_d;
	end

	// Same pixel twice in a row with the same configuration.
	assign repeat_pix = acc && prev_acc_q && !prev_we_q && (sample_a == prev_a_q) &&
		(sample_b == prev_b_q) && (sample_c == prev_c_q) && (sample_d == prev_d_q);

	`JPCT_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy, "busy raised")
	`JPCT_ASSERT_IMPLY(a_done_has_source, clk, arst_n, done, $past(acc, LAT), "done without a transaction")
	`JPCT_ASSERT_IMPLY(a_run_end_copy, clk, arst_n, done, run_end_out == $past(end_of_run, LAT), "run end mismatch")
	`JPCT_ASSERT_IMPLY(a_repeat_same, clk, arst_n, done && $past(repeat_pix, LAT), (red_out == $past(red_out)) && (green_out == $past(green_out)) && (blue_out == $past(blue_out)) && (alpha_out == $past(alpha_out)), "repeated pixel differs")

	// cfg_addr and cfg_wdata feed a check that writes never meet busy.
	logic cfg_seen;
	assign cfg_seen = cfg_we && ((cfg_addr != 2'b00) || (cfg_wdata != 16'h0000));

	`JPCT_ASSERT_IMPLY(a_cfg_no_accept_effect, clk, arst_n, cfg_seen, !busy, "busy on configuration write")

endmodule

bind jpeg_pixel_color_transfer_top jpct_checker u_jpct_checker (.*);
